@@ src/wtsb_pkg.sv @@
// Shared constants, types and helpers of the wrapped texture sampler.
`default_nettype none

package wtsb_pkg;

	localparam int MAX_TEXELS = 65536;
	localparam int MAX_SIDE   = 256;
	localparam int FRAC_BITS  = 16;

	localparam int ADDR_W  = $clog2(MAX_TEXELS);
	localparam int COORD_W = $clog2(MAX_SIDE);
	localparam int SIDE_W  = COORD_W + 1;
	localparam int UV_W    = 32;
	localparam int CH_W    = 8;
	localparam int TEXEL_W = 3 * CH_W;
	localparam int CFG_W   = 9;
	localparam int QDEPTH  = 2;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_FILTER = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		op_t                op;
		logic [ADDR_W-1:0]  addr;
		logic [TEXEL_W-1:0] texel;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [SIDE_W-1:0]  w;
		logic [SIDE_W-1:0]  h;
		logic               filt;
	} wtsb_entry_t;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] s);
		logic [SIDE_W-1:0] r;
		if (s == '0) begin
			r = SIDE_W'(1);
		end else if (s > CFG_W'(MAX_SIDE)) begin
			r = SIDE_W'(MAX_SIDE);
		end else begin
			r = SIDE_W'(s);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/wtsb_front.sv @@
// Front end: configuration registers, item intake and texel coordinate mapping.
`default_nettype none

module wtsb_front import wtsb_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output      logic                 busy,
	input  wire logic                 op,
	input  wire logic [ADDR_W-1:0]    texel_index,
	input  wire logic [CH_W-1:0]      red_in,
	input  wire logic [CH_W-1:0]      green_in,
	input  wire logic [CH_W-1:0]      blue_in,
	input  wire logic signed [UV_W-1:0] u_coord,
	input  wire logic signed [UV_W-1:0] v_coord,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output      logic                 push_valid,
	output      wtsb_entry_t          push_entry,
	input  wire logic                 q_full
);

	logic [SIDE_W-1:0] width_q, height_q;
	logic              filter_q;

	logic                 v_s1;
	op_t                  op_s1;
	logic [ADDR_W-1:0]    addr_s1;
	logic [TEXEL_W-1:0]   texel_s1;
	logic [FRAC_BITS-1:0] fu_s1, fv_s1;
	logic [SIDE_W-1:0]    w_s1, h_s1;
	logic                 filt_s1;

	logic                          accept;
	logic [FRAC_BITS+SIDE_W-1:0]   prod_x;
	logic [FRAC_BITS:0]            vinv;
	logic [FRAC_BITS+SIDE_W:0]     prod_y;
	logic [SIDE_W-1:0]             x_raw;
	logic [SIDE_W:0]               y_raw;
	logic [COORD_W-1:0]            x_map, y_map;

	assign busy   = v_s1 && q_full;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIDE_W'(MAX_SIDE);
			height_q <= SIDE_W'(MAX_SIDE);
			filter_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= clamp_side(cfg_data);
				REG_HEIGHT: height_q <= clamp_side(cfg_data);
				REG_FILTER: filter_q <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (!q_full) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op_t'(op);
			addr_s1  <= texel_index;
			texel_s1 <= {red_in, green_in, blue_in};
			fu_s1    <= u_coord[FRAC_BITS-1:0];
			fv_s1    <= v_coord[FRAC_BITS-1:0];
			w_s1     <= width_q;
			h_s1     <= height_q;
			filt_s1  <= filter_q && (width_q > SIDE_W'(1)) && (height_q > SIDE_W'(1));
		end
	end

	always_comb begin
		prod_x = {{SIDE_W{1'b0}}, fu_s1} * {{FRAC_BITS{1'b0}}, w_s1};
		x_raw  = prod_x[FRAC_BITS +: SIDE_W];
		x_map  = (x_raw >= w_s1) ? '0 : x_raw[COORD_W-1:0];
		vinv   = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, fv_s1};
		prod_y = {{SIDE_W{1'b0}}, vinv} * {{(FRAC_BITS+1){1'b0}}, h_s1};
		y_raw  = prod_y[FRAC_BITS +: (SIDE_W+1)];
		y_map  = (y_raw >= {1'b0, h_s1}) ? '0 : y_raw[COORD_W-1:0];
	end

	assign push_valid       = v_s1;
	assign push_entry.op    = op_s1;
	assign push_entry.addr  = addr_s1;
	assign push_entry.texel = texel_s1;
	assign push_entry.x     = x_map;
	assign push_entry.y     = y_map;
	assign push_entry.w     = w_s1;
	assign push_entry.h     = h_s1;
	assign push_entry.filt  = filt_s1;

endmodule

`default_nettype wire

@@ src/wtsb_queue.sv @@
// Short queue of classified items between the front end and the texel engine.
`default_nettype none

module wtsb_queue import wtsb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push_valid,
	input  wire wtsb_entry_t push_entry,
	output      logic        full,
	output      logic        head_valid,
	output      wtsb_entry_t head_entry,
	input  wire logic        pop
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	wtsb_entry_t        slot_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign full       = (count_q == CNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];
	assign do_push    = push_valid && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= CNT_W'(count_q + 1'b1);
				2'b01:   count_q <= CNT_W'(count_q - 1'b1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

@@ src/wtsb_back.sv @@
// Texel engine: texture memory, neighbourhood read sequencer, accumulation and averaging.
`default_nettype none

module wtsb_back import wtsb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  wire wtsb_entry_t head_entry,
	output      logic        pop,
	output      logic        done,
	output      logic [CH_W-1:0] red_out,
	output      logic [CH_W-1:0] green_out,
	output      logic [CH_W-1:0] blue_out
);

	localparam int SUM_W = 12;
	localparam int DIV9_SHIFT = 15;
	localparam logic [SUM_W-1:0] DIV9_MUL = SUM_W'(3641);
	localparam logic [SUM_W-1:0] ROUND_ADD = SUM_W'(4);
	localparam logic [1:0] STEP_LO  = 2'd0;
	localparam logic [1:0] STEP_MID = 2'd1;
	localparam logic [1:0] STEP_HI  = 2'd2;

	function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0]   t;
		logic [2*SUM_W-1:0] p;
		t = s + ROUND_ADD;
		p = {{SUM_W{1'b0}}, t} * {{SUM_W{1'b0}}, DIV9_MUL};
		return p[DIV9_SHIFT +: CH_W];
	endfunction

	logic [TEXEL_W-1:0] mem [MAX_TEXELS];

	logic               act_q;
	wtsb_entry_t        cur_q;
	logic [COORD_W-1:0] xm_q, xp_q, ym_q, yp_q;
	logic [1:0]         dx_q, dy_q;

	logic               last_issue;
	logic               first_issue;
	logic [COORD_W-1:0] xx, yy;
	logic [COORD_W-1:0] hx_m, hx_p, hy_m, hy_p;
	logic [COORD_W+SIDE_W-1:0] lin;

	logic               we_s1, rd_s1, first_s1, last_s1, filt_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [TEXEL_W-1:0] wdata_s1;

	logic               rd_s2, first_s2, last_s2, filt_s2;
	logic [TEXEL_W-1:0] rdata_s2;

	logic [SUM_W-1:0]   sum_r_q, sum_g_q, sum_b_q;
	logic               fin_q, fin_filt_q;
	logic               done_q;
	logic [CH_W-1:0]    red_q, green_q, blue_q;

	assign last_issue  = act_q && ((cur_q.op == OP_LOAD) || !cur_q.filt ||
	                               ((dx_q == STEP_HI) && (dy_q == STEP_HI)));
	assign first_issue = !cur_q.filt || ((dx_q == STEP_LO) && (dy_q == STEP_LO));
	assign pop         = head_valid && (!act_q || last_issue);

	always_comb begin
		hx_m = (head_entry.x == '0) ? COORD_W'(head_entry.w - 1'b1) : COORD_W'(head_entry.x - 1'b1);
		hx_p = ({1'b0, head_entry.x} + 1'b1 == head_entry.w) ? '0 : COORD_W'(head_entry.x + 1'b1);
		hy_m = (head_entry.y == '0) ? COORD_W'(head_entry.h - 1'b1) : COORD_W'(head_entry.y - 1'b1);
		hy_p = ({1'b0, head_entry.y} + 1'b1 == head_entry.h) ? '0 : COORD_W'(head_entry.y + 1'b1);
	end

	always_comb begin
		case (dx_q)
			STEP_LO:  xx = xm_q;
			STEP_MID: xx = cur_q.x;
			default:  xx = xp_q;
		endcase
		case (dy_q)
			STEP_LO:  yy = ym_q;
			STEP_MID: yy = cur_q.y;
			default:  yy = yp_q;
		endcase
		lin = {{SIDE_W{1'b0}}, yy} * {{COORD_W{1'b0}}, cur_q.w} + {{SIDE_W{1'b0}}, xx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			dx_q  <= STEP_LO;
			dy_q  <= STEP_LO;
		end else if (pop) begin
			act_q <= 1'b1;
			dx_q  <= head_entry.filt ? STEP_LO : STEP_MID;
			dy_q  <= head_entry.filt ? STEP_LO : STEP_MID;
		end else if (act_q) begin
			if (last_issue) begin
				act_q <= 1'b0;
			end else if (dx_q == STEP_HI) begin
				dx_q <= STEP_LO;
				dy_q <= 2'(dy_q + 1'b1);
			end else begin
				dx_q <= 2'(dx_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_entry;
			xm_q  <= hx_m;
			xp_q  <= hx_p;
			ym_q  <= hy_m;
			yp_q  <= hy_p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s1 <= 1'b0;
			rd_s1 <= 1'b0;
			rd_s2 <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			we_s1  <= act_q && (cur_q.op == OP_LOAD);
			rd_s1  <= act_q && (cur_q.op == OP_SAMPLE);
			rd_s2  <= rd_s1;
			fin_q  <= rd_s2 && last_s2;
			done_q <= fin_q;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1  <= (cur_q.op == OP_LOAD) ? cur_q.addr : lin[ADDR_W-1:0];
		wdata_s1 <= cur_q.texel;
		first_s1 <= first_issue;
		last_s1  <= last_issue;
		filt_s1  <= cur_q.filt;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		filt_s2  <= filt_s1;
	end

	always_ff @(posedge clk) begin
		if (we_s1) begin
			mem[addr_s1] <= wdata_s1;
		end else begin
			rdata_s2 <= mem[addr_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s2) begin
			if (first_s2) begin
				sum_r_q <= {{(SUM_W-CH_W){1'b0}}, rdata_s2[3*CH_W-1:2*CH_W]};
				sum_g_q <= {{(SUM_W-CH_W){1'b0}}, rdata_s2[2*CH_W-1:CH_W]};
				sum_b_q <= {{(SUM_W-CH_W){1'b0}}, rdata_s2[CH_W-1:0]};
			end else begin
				sum_r_q <= sum_r_q + {{(SUM_W-CH_W){1'b0}}, rdata_s2[3*CH_W-1:2*CH_W]};
				sum_g_q <= sum_g_q + {{(SUM_W-CH_W){1'b0}}, rdata_s2[2*CH_W-1:CH_W]};
				sum_b_q <= sum_b_q + {{(SUM_W-CH_W){1'b0}}, rdata_s2[CH_W-1:0]};
			end
			if (last_s2) begin
				fin_filt_q <= filt_s2;
			end
		end
		if (fin_q) begin
			red_q   <= fin_filt_q ? div9(sum_r_q) : sum_r_q[CH_W-1:0];
			green_q <= fin_filt_q ? div9(sum_g_q) : sum_g_q[CH_W-1:0];
			blue_q  <= fin_filt_q ? div9(sum_b_q) : sum_b_q[CH_W-1:0];
		end
	end

	assign done      = done_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;

endmodule

`default_nettype wire

@@ src/wrapped_texture_sampler_box3x3.sv @@
// Top level of the wrapped texture sampler with optional 3x3 box filter.
//
// Items enter through start/busy: an item is taken at a clock edge where start is high
// and busy is low. op selects a texel load (texel_index, red_in, green_in, blue_in) or a
// sample at signed 16.16 coordinates (u_coord, v_coord). Loads give no result.
// Each sample gives one result on red_out/green_out/blue_out, shown for one cycle with
// done high; the receiver always takes it.
// Registers are written through cfg_valid/cfg_ready (always ready), cfg_index 0 width,
// 1 height, 2 filter enable; write only while no item is in flight.
// The front end takes one item a cycle while its two-entry queue has room. The texel
// engine makes one access of the single-port texture memory per load or nearest sample
// and nine reads per filtered sample, one per neighbour; that memory port sets the rate.
// Reset clears all control state and restores width 256, height 256, filter off; the
// texture memory is not cleared and must be loaded before it is sampled.
`default_nettype none

module wrapped_texture_sampler_box3x3 import wtsb_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output      logic                   busy,
	input  wire logic                   op,
	input  wire logic [ADDR_W-1:0]      texel_index,
	input  wire logic [CH_W-1:0]        red_in,
	input  wire logic [CH_W-1:0]        green_in,
	input  wire logic [CH_W-1:0]        blue_in,
	input  wire logic signed [UV_W-1:0] u_coord,
	input  wire logic signed [UV_W-1:0] v_coord,
	input  wire logic                   cfg_valid,
	output      logic                   cfg_ready,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data,
	output      logic                   done,
	output      logic [CH_W-1:0]        red_out,
	output      logic [CH_W-1:0]        green_out,
	output      logic [CH_W-1:0]        blue_out
);

	logic        push_valid, q_full, head_valid, pop;
	wtsb_entry_t push_entry, head_entry;

	assign cfg_ready = 1'b1;

	wtsb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.texel_index (texel_index),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.u_coord     (u_coord),
		.v_coord     (v_coord),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push_valid  (push_valid),
		.push_entry  (push_entry),
		.q_full      (q_full)
	);

	wtsb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.full       (q_full),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop)
	);

	wtsb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.done       (done),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out)
	);

endmodule

`default_nettype wire

@@ src/wtsb_checker.sv @@
// Port-level checker of the texture sampler and its binding to the top level.
`default_nettype none

module wtsb_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic done
);

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration transfer refused");

	a_no_busy_unprompted: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> !busy)
		else $error("busy raised without an accepted item");

	a_known_handshake: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({busy, done, cfg_ready}))
		else $error("handshake output unknown");

	a_no_result_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !done)
		else $error("result straight after reset");

endmodule

bind wrapped_texture_sampler_box3x3 wtsb_checker u_wtsb_checker (.*);

`default_nettype wire
